@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define CDM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same check on the block's own clock and reset names.
`define CDM_ASSERT_CLK(label, prop, msg) \
  `CDM_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/cdm_pkg.sv @@
// ----------------------------------------------------------------------------
// cdm_pkg
// Types, constants and the sine table of the curvature drive mixer.
// ----------------------------------------------------------------------------
package cdm_pkg;

  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned SINE_FRAC_BITS  = 30 - SINE_TABLE_BITS;
  localparam int unsigned SINE_POINTS     = (2 ** SINE_TABLE_BITS) + 1;
  localparam int unsigned SINE_ADDR_W     = SINE_TABLE_BITS + 1;

  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam int unsigned DIV_STEPS = 30;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [63:0] SC1 = 64'd1686629713;
  localparam logic [63:0] SC3 = 64'd693598669;
  localparam logic [63:0] SC5 = 64'd85569299;
  localparam logic [63:0] SC7 = 64'd5026994;
  localparam logic [63:0] SC9 = 64'd172271;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADBAND    = 3'd0,
    CFG_SLEW        = 3'd1,
    CFG_NONLINEAR   = 3'd2,
    CFG_INERTIA     = 3'd3,
    CFG_SENSITIVITY = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PH_DEN,
    OP_PH_NUM,
    OP_SIN_A,
    OP_SIN_B,
    OP_SIN_C,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_FIN_A,
    OP_FIN_B,
    OP_FIN_C,
    OP_COMMIT
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PH_DEN,
    ST_PH_NUM,
    ST_SIN_A,
    ST_SIN_B,
    ST_SIN_C,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_END,
    ST_FIN_A,
    ST_FIN_B,
    ST_FIN_C,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e  op;
    logic den_sel;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  typedef logic [30:0] sine_rom_t [0:SINE_POINTS-1];

  // Quarter-wave sine points, odd polynomial in Q30, clamped to one.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] a;
    logic [63:0] r;
    for (int i = 0; i < SINE_POINTS; i++) begin
      t  = 64'(i) << SINE_FRAC_BITS;
      t2 = (t * t) >> 30;
      a  = SC9;
      a  = SC7 - ((a * t2) >> 30);
      a  = SC5 - ((a * t2) >> 30);
      a  = SC3 - ((a * t2) >> 30);
      a  = SC1 - ((a * t2) >> 30);
      r  = (a * t) >> 30;
      rom[i] = (r > 64'(ONE_Q30)) ? ONE_Q30 : r[30:0];
    end
    return rom;
  endfunction

endpackage

@@ rtl/cdm_if.sv @@
// ----------------------------------------------------------------------------
// cdm_in_if / cdm_out_if
// Valid/ready channels for joystick samples and drive commands.
// ----------------------------------------------------------------------------
interface cdm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] throttle_in;
  logic signed [15:0] turn_in;

  modport source (output valid, output throttle_in, output turn_in, input ready);
  modport sink   (input valid, input throttle_in, input turn_in, output ready);
endinterface

interface cdm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] linear_out;
  logic signed [17:0] angular_out;
  logic               turn_in_place;

  modport source (output valid, output linear_out, output angular_out,
                  output turn_in_place, input ready);
  modport sink   (input valid, input linear_out, input angular_out,
                  input turn_in_place, output ready);
endinterface

@@ rtl/curvature_drive_mixer_top.sv @@
// ----------------------------------------------------------------------------
// curvature_drive_mixer_top
// Curvature drive mixer: throttle and turn samples in, linear and angular
// drive commands out.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// in_i      sink       throttle_in, turn_in (Q1.15)
// out_o     source     linear_out (Q1.15), angular_out (Q3.15), turn_in_place
// cfg       write      cfg_we_i, cfg_idx_i, cfg_data_i
//
// No new sample is taken until the last one commits; its result shows on
// out_o in the same cycle that ready returns. Two 30-step
// restoring divisions of the turn remap and three sine table lookups of
// two reads each make up most of a sample's run.
// A new sample is taken while a finished result still waits on out_o; the
// next result then holds in the last step until out_o drains.
// Reset clears history and configuration to defaults; no clearing pass.
// ----------------------------------------------------------------------------
module curvature_drive_mixer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cdm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cdm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  cdm_in_if.sink                         in_i,
  cdm_out_if.source                      out_o
);

  cdm_pkg::cmd_t  cmd;
  cdm_pkg::stat_t stat;

  cdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cdm_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .throttle_i (in_i.throttle_in),
    .turn_i     (in_i.turn_in),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_o      (out_o)
  );

endmodule

@@ rtl/cdm_datapath.sv @@
// ----------------------------------------------------------------------------
// cdm_datapath
// Registers, sine table, shared divider and mixing arithmetic of the mixer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdm_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cdm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cdm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic signed [15:0]               throttle_i,
  input  logic signed [15:0]               turn_i,
  input  cdm_pkg::cmd_t                    cmd_i,
  output cdm_pkg::stat_t                   stat_o,
  cdm_out_if.source                        out_o
);

  localparam cdm_pkg::sine_rom_t SineRom = cdm_pkg::build_sine_rom();
  localparam int unsigned FB = cdm_pkg::SINE_FRAC_BITS;
  localparam int unsigned AW = cdm_pkg::SINE_ADDR_W;
  localparam logic [AW-1:0] LastAddr = AW'(cdm_pkg::SINE_POINTS - 1);

  // configuration
  logic [14:0] db_q, slew_q;
  logic [15:0] knl_q, gain_q, sens_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_q   <= 15'd1638;
      slew_q <= 15'd3277;
      knl_q  <= 16'd16384;
      gain_q <= 16'd16384;
      sens_q <= 16'd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cdm_pkg::CFG_DEADBAND:    db_q   <= cfg_data_i[14:0];
        cdm_pkg::CFG_SLEW:        slew_q <= cfg_data_i[14:0];
        cdm_pkg::CFG_NONLINEAR:   knl_q  <= cfg_data_i;
        cdm_pkg::CFG_INERTIA:     gain_q <= cfg_data_i;
        cdm_pkg::CFG_SENSITIVITY: sens_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // history
  logic signed [15:0] last_thr_q, last_turn_q;
  logic signed [21:0] acc_q;

  // per-sample registers
  logic signed [15:0] thr_q, turn_q, lin_q;
  logic               tip_q, rneg_q;
  logic [30:0]        x_q;
  logic [15:0]        kc_q;
  logic [30:0]        ph_q, s0_q, sd_q, sn_q, rom_q;
  logic [31:0]        rem_q;
  logic [30:0]        quo_q;
  logic               skip_q;
  logic signed [21:0] accn_q;
  logic [37:0]        smag_q;
  logic               sum_neg_q;
  logic [23:0]        t1_q;
  logic signed [17:0] ang_q;

  // output register
  logic               out_valid_q;
  logic signed [15:0] out_lin_q;
  logic signed [17:0] out_ang_q;
  logic               out_tip_q;

  // ---- sample load: deadband, slew limit ----
  logic signed [16:0] v_ext, w_ext, last_ext, dv;
  logic [16:0]        mag_v, mag_w, db_ext;
  logic signed [17:0] dv18, s18, two_s, last18, lin18;
  logic               tip_d;

  always_comb begin
    v_ext    = {throttle_i[15], throttle_i};
    w_ext    = {turn_i[15], turn_i};
    last_ext = {last_thr_q[15], last_thr_q};
    mag_v    = throttle_i[15] ? 17'(-v_ext) : 17'(v_ext);
    mag_w    = turn_i[15] ? 17'(-w_ext) : 17'(w_ext);
    db_ext   = {2'b00, db_q};
    tip_d    = (mag_v < db_ext) && (mag_w > db_ext);
    dv       = v_ext - last_ext;
    dv18     = {dv[16], dv};
    s18      = $signed({3'b000, slew_q});
    two_s    = $signed({2'b00, slew_q, 1'b0});
    last18   = {{2{last_thr_q[15]}}, last_thr_q};
    if (tip_d) begin
      lin18 = '0;
    end else if (dv18 > s18) begin
      lin18 = last18 + s18;
    end else if (dv18 < -two_s) begin
      lin18 = last18 - two_s;
    end else begin
      lin18 = {{2{throttle_i[15]}}, throttle_i};
    end
  end

  // ---- phase and sine interpolation ----
  logic [46:0]           kx;
  logic [30:0]           ph_raw, ph_d;
  logic [AW-1:0]         idx, rom_addr;
  logic [FB-1:0]         frac;
  logic [30:0]           sdiff;
  logic [30+FB:0]        interp;
  logic [30:0]           sine_val;

  always_comb begin
    kx       = kc_q * x_q;
    ph_raw   = (cmd_i.op == cdm_pkg::OP_PH_DEN) ? {kc_q, 15'b0} : kx[45:15];
    ph_d     = (ph_raw > cdm_pkg::ONE_Q30) ? cdm_pkg::ONE_Q30 : ph_raw;
    idx      = ph_q[30:FB];
    frac     = ph_q[FB-1:0];
    rom_addr = idx;
    if (cmd_i.op == cdm_pkg::OP_SIN_B) begin
      rom_addr = (idx == LastAddr) ? idx : idx + AW'(1);
    end
    sdiff    = (rom_q > s0_q) ? rom_q - s0_q : '0;
    interp   = sdiff * frac;
    sine_val = s0_q + interp[30+FB:FB];
  end

  always_ff @(posedge clk_i) begin
    rom_q <= SineRom[rom_addr];
  end

  // ---- divider step ----
  logic [31:0] rem_sh;
  logic [32:0] rem_sub;

  always_comb begin
    rem_sh  = {rem_q[30:0], 1'b0};
    rem_sub = {1'b0, rem_sh} - {2'b00, sd_q};
  end

  // ---- mixing ----
  logic [61:0]        sq;
  logic [16:0]        tip_mag;
  logic signed [16:0] dw;
  logic signed [33:0] p;
  logic [33:0]        p_abs;
  logic [19:0]        pm;
  logic signed [23:0] acc_sum;
  logic signed [21:0] acc_sat;
  logic signed [38:0] sum, rterm;
  logic [15:0]        lin_mag;
  logic [53:0]        lp;
  logic [39:0]        t2;
  logic [27:0]        tt;
  logic signed [17:0] ang_d;
  logic signed [21:0] acc_decay;

  always_comb begin
    sq      = x_q * x_q;
    tip_mag = sq[61:45];
    dw      = {turn_q[15], turn_q} - {last_turn_q[15], last_turn_q};
    p       = dw * $signed({1'b0, gain_q});
    p_abs   = p[33] ? 34'(-p) : 34'(p);
    pm      = p_abs[31:12];
    acc_sum = p[33] ? ({{2{acc_q[21]}}, acc_q} - $signed({4'b0, pm}))
                    : ({{2{acc_q[21]}}, acc_q} + $signed({4'b0, pm}));
    if (acc_sum > 24'sd2097151) begin
      acc_sat = 22'sd2097151;
    end else if (acc_sum < -24'sd2097152) begin
      acc_sat = -22'sd2097152;
    end else begin
      acc_sat = acc_sum[21:0];
    end
    rterm   = rneg_q ? -$signed({8'b0, x_q}) : $signed({8'b0, x_q});
    sum     = $signed({acc_sat[21], acc_sat[21], acc_sat, 15'b0}) + rterm;
    lin_mag = lin_q[15] ? 16'(-lin_q) : 16'(lin_q);
    lp      = lin_mag * smag_q;
    t2      = t1_q * sens_q;
    tt      = t2[39:12];
    if (sum_neg_q) begin
      ang_d = (tt > 28'd131072) ? -18'sd131072 : -$signed(tt[17:0]);
    end else begin
      ang_d = (tt > 28'd131071) ? 18'sd131071 : $signed(tt[17:0]);
    end
    if (accn_q > 22'sd32768) begin
      acc_decay = accn_q - 22'sd32768;
    end else if (accn_q < -22'sd32768) begin
      acc_decay = accn_q + 22'sd32768;
    end else begin
      acc_decay = '0;
    end
  end

  // ---- working registers ----
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      cdm_pkg::OP_LOAD: begin
        thr_q  <= throttle_i;
        turn_q <= turn_i;
        tip_q  <= tip_d;
        rneg_q <= turn_i[15];
        lin_q  <= lin18[15:0];
        x_q    <= {mag_w[15:0], 15'b0};
        kc_q   <= (knl_q > 16'd32768) ? 16'd32768 : knl_q;
      end
      cdm_pkg::OP_PH_DEN, cdm_pkg::OP_PH_NUM: ph_q <= ph_d;
      cdm_pkg::OP_SIN_B: s0_q <= rom_q;
      cdm_pkg::OP_SIN_C: begin
        if (cmd_i.den_sel) begin
          sd_q <= sine_val;
        end else begin
          sn_q <= sine_val;
        end
      end
      cdm_pkg::OP_DIV_INIT: begin
        rem_q <= {1'b0, sn_q};
        if (sd_q == '0) begin
          quo_q  <= x_q;
          skip_q <= 1'b1;
        end else if (sn_q >= sd_q) begin
          quo_q  <= cdm_pkg::ONE_Q30;
          skip_q <= 1'b1;
        end else begin
          quo_q  <= '0;
          skip_q <= 1'b0;
        end
      end
      cdm_pkg::OP_DIV_STEP: begin
        if (!skip_q) begin
          if (!rem_sub[32]) begin
            rem_q <= rem_sub[31:0];
            quo_q <= {quo_q[29:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[29:0], 1'b0};
          end
        end
      end
      cdm_pkg::OP_DIV_END: x_q <= quo_q;
      cdm_pkg::OP_FIN_A: begin
        accn_q    <= acc_sat;
        smag_q    <= sum[38] ? 38'(-sum) : 38'(sum);
        sum_neg_q <= sum[38];
        ang_q     <= rneg_q ? -$signed({1'b0, tip_mag}) : $signed({1'b0, tip_mag});
      end
      cdm_pkg::OP_FIN_B: t1_q <= lp[53:30];
      cdm_pkg::OP_FIN_C: begin
        if (!tip_q) begin
          ang_q <= ang_d;
        end
      end
      default: ;
    endcase
  end

  // ---- history and output ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_thr_q  <= '0;
      last_turn_q <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == cdm_pkg::OP_COMMIT) begin
      last_thr_q  <= thr_q;
      last_turn_q <= turn_q;
      if (!tip_q) begin
        acc_q <= acc_decay;
      end
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == cdm_pkg::OP_COMMIT) begin
      out_lin_q <= lin_q;
      out_ang_q <= ang_q;
      out_tip_q <= tip_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.linear_out    = out_lin_q;
  assign out_o.angular_out   = out_ang_q;
  assign out_o.turn_in_place = out_tip_q;
  assign stat_o.out_busy     = out_valid_q && !out_o.ready;

  `CDM_ASSERT_CLK(a_commit_free,
    (cmd_i.op == cdm_pkg::OP_COMMIT) |-> !(out_valid_q && !out_o.ready),
    "result committed over a pending transaction")
  `CDM_ASSERT_CLK(a_quo_range,
    (cmd_i.op == cdm_pkg::OP_DIV_END) |-> (quo_q <= cdm_pkg::ONE_Q30),
    "remap quotient above one")
  `CDM_ASSERT(a_tip_lin, clk_i, rst_ni,
    (out_valid_q && out_tip_q) |-> (out_lin_q == 16'sd0),
    "point turn with nonzero linear command")

endmodule

@@ rtl/cdm_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdm_ctrl
// Sequencer: sine lookups, two remap divisions, mixing and result commit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cdm_pkg::stat_t stat_i,
  output cdm_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    PASS_DEN,
    PASS_FIRST,
    PASS_SECOND
  } pass_e;

  cdm_pkg::state_e state_q, state_d;
  pass_e           pass_q, pass_d;
  logic [cdm_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;

  localparam logic [cdm_pkg::DIV_CNT_W-1:0] LastStep =
    cdm_pkg::DIV_CNT_W'(cdm_pkg::DIV_STEPS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdm_pkg::ST_IDLE;
      pass_q  <= PASS_DEN;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    cnt_d   = cnt_q;
    case (state_q)
      cdm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = cdm_pkg::ST_PH_DEN;
          pass_d  = PASS_DEN;
        end
      end
      cdm_pkg::ST_PH_DEN: state_d = cdm_pkg::ST_SIN_A;
      cdm_pkg::ST_PH_NUM: state_d = cdm_pkg::ST_SIN_A;
      cdm_pkg::ST_SIN_A:  state_d = cdm_pkg::ST_SIN_B;
      cdm_pkg::ST_SIN_B:  state_d = cdm_pkg::ST_SIN_C;
      cdm_pkg::ST_SIN_C: begin
        if (pass_q == PASS_DEN) begin
          state_d = cdm_pkg::ST_PH_NUM;
          pass_d  = PASS_FIRST;
        end else begin
          state_d = cdm_pkg::ST_DIV_INIT;
        end
      end
      cdm_pkg::ST_DIV_INIT: begin
        state_d = cdm_pkg::ST_DIV_STEP;
        cnt_d   = '0;
      end
      cdm_pkg::ST_DIV_STEP: begin
        if (cnt_q == LastStep) begin
          state_d = cdm_pkg::ST_DIV_END;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      cdm_pkg::ST_DIV_END: begin
        if (pass_q == PASS_FIRST) begin
          state_d = cdm_pkg::ST_PH_NUM;
          pass_d  = PASS_SECOND;
        end else begin
          state_d = cdm_pkg::ST_FIN_A;
        end
      end
      cdm_pkg::ST_FIN_A: state_d = cdm_pkg::ST_FIN_B;
      cdm_pkg::ST_FIN_B: state_d = cdm_pkg::ST_FIN_C;
      cdm_pkg::ST_FIN_C: state_d = cdm_pkg::ST_DONE;
      cdm_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!stat_i.out_busy) begin
          state_d = cdm_pkg::ST_IDLE;
        end
      end
      default: state_d = cdm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.op      = cdm_pkg::OP_NONE;
    cmd_o.den_sel = (pass_q == PASS_DEN);
    case (state_q)
      cdm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = cdm_pkg::OP_LOAD;
        end
      end
      cdm_pkg::ST_PH_DEN:   cmd_o.op = cdm_pkg::OP_PH_DEN;
      cdm_pkg::ST_PH_NUM:   cmd_o.op = cdm_pkg::OP_PH_NUM;
      cdm_pkg::ST_SIN_A:    cmd_o.op = cdm_pkg::OP_SIN_A;
      cdm_pkg::ST_SIN_B:    cmd_o.op = cdm_pkg::OP_SIN_B;
      cdm_pkg::ST_SIN_C:    cmd_o.op = cdm_pkg::OP_SIN_C;
      cdm_pkg::ST_DIV_INIT: cmd_o.op = cdm_pkg::OP_DIV_INIT;
      cdm_pkg::ST_DIV_STEP: cmd_o.op = cdm_pkg::OP_DIV_STEP;
      cdm_pkg::ST_DIV_END:  cmd_o.op = cdm_pkg::OP_DIV_END;
      cdm_pkg::ST_FIN_A:    cmd_o.op = cdm_pkg::OP_FIN_A;
      cdm_pkg::ST_FIN_B:    cmd_o.op = cdm_pkg::OP_FIN_B;
      cdm_pkg::ST_FIN_C:    cmd_o.op = cdm_pkg::OP_FIN_C;
      cdm_pkg::ST_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = cdm_pkg::OP_COMMIT;
        end
      end
      default: ;
    endcase
  end

  `CDM_ASSERT_CLK(a_step_count,
    (state_q == cdm_pkg::ST_DIV_STEP) |-> (cnt_q <= LastStep),
    "divider step count out of range")
  `CDM_ASSERT_CLK(a_done_release,
    (state_q == cdm_pkg::ST_DONE && !stat_i.out_busy) |=> (state_q == cdm_pkg::ST_IDLE),
    "sequencer did not return to idle after commit")
  `CDM_ASSERT_CLK(a_ready_idle,
    in_ready_o |-> (state_q == cdm_pkg::ST_IDLE),
    "input ready outside idle")

endmodule

@@ bench/curvature_drive_mixer_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// curvature_drive_mixer_top_tb
// Self-checking bench for the curvature drive mixer. A scoreboard class keeps
// its own bit-true model of the remap, slew and inertia path and predicts
// every drive command. Samples go in bursts with random gaps, the command
// side stalls on its own pattern, and the registers are rewritten between
// phases, extremes included.
// ----------------------------------------------------------------------------
module curvature_drive_mixer_top_tb;

  typedef struct {
    logic signed [15:0] linear;
    logic signed [17:0] angular;
    logic               point_turn;
  } drive_cmd_t;

  class drive_scoreboard;
    longint unsigned sine_pts [0:1024];
    int unsigned deadband, slew, nonlin, gain, sens;
    int          last_thr, last_turn, inertia;
    drive_cmd_t  pending_cmds [$];
    int          n_checked;
    int          n_point_turns;

    function new();
      longint unsigned t, t2, a, r;
      for (int i = 0; i <= 1024; i++) begin
        t  = longint'(i) << 20;
        t2 = (t * t) >> 30;
        a  = 64'd172271;
        a  = 64'd5026994 - ((a * t2) >> 30);
        a  = 64'd85569299 - ((a * t2) >> 30);
        a  = 64'd693598669 - ((a * t2) >> 30);
        a  = 64'd1686629713 - ((a * t2) >> 30);
        r  = (a * t) >> 30;
        sine_pts[i] = (r > 64'd1073741824) ? 64'd1073741824 : r;
      end
      deadband = 1638;
      slew     = 3277;
      nonlin   = 16384;
      gain     = 16384;
      sens     = 4096;
      last_thr = 0;
      last_turn = 0;
      inertia  = 0;
      n_checked = 0;
      n_point_turns = 0;
    endfunction

    function void write_reg(cdm_pkg::cfg_idx_e idx, int unsigned val);
      case (idx)
        cdm_pkg::CFG_DEADBAND:    deadband = val & 32'h7FFF;
        cdm_pkg::CFG_SLEW:        slew     = val & 32'h7FFF;
        cdm_pkg::CFG_NONLINEAR:   nonlin   = val & 32'hFFFF;
        cdm_pkg::CFG_INERTIA:     gain     = val & 32'hFFFF;
        cdm_pkg::CFG_SENSITIVITY: sens     = val & 32'hFFFF;
        default: ;
      endcase
    endfunction

    function longint unsigned quarter_sine(longint unsigned ph);
      longint unsigned idx, frac, s0, s1, d;
      if (ph > 64'd1073741824) ph = 64'd1073741824;
      idx  = ph >> 20;
      frac = ph & 64'hF_FFFF;
      s0   = sine_pts[idx];
      if (frac == 0) return s0;
      s1 = sine_pts[idx + 1];
      d  = (s1 > s0) ? s1 - s0 : 0;
      return s0 + ((d * frac) >> 20);
    endfunction

    function longint unsigned remap(longint unsigned mag, longint unsigned k);
      longint unsigned sn, sd, q;
      sn = quarter_sine((k * mag) >> 15);
      sd = quarter_sine(k << 15);
      if (sd == 0) return mag;
      q = (sn << 30) / sd;
      return (q > 64'd1073741824) ? 64'd1073741824 : q;
    endfunction

    function void note_sample(int v, int w);
      drive_cmd_t      c;
      int              lin, dv;
      longint          ang, p, acc, s;
      longint unsigned k, rmag, m, pm, smag, t, vmag, wmag, lmag;
      bit              point_turn;
      lin  = v;
      dv   = v - last_thr;
      k    = (nonlin > 32768) ? 32768 : nonlin;
      vmag = (v < 0) ? -v : v;
      wmag = (w < 0) ? -w : w;
      point_turn = 0;
      if (vmag < deadband && wmag > deadband) begin
        lin = 0;
        point_turn = 1;
      end else if (dv > int'(slew)) begin
        lin = last_thr + int'(slew);
      end else if (dv < -2 * int'(slew)) begin
        lin = last_thr - 2 * int'(slew);
      end
      rmag = remap(remap(wmag << 15, k), k);
      if (point_turn) begin
        m   = (rmag * rmag) >> 45;
        ang = (w < 0) ? -longint'(m) : longint'(m);
        n_point_turns++;
      end else begin
        p   = longint'(w - last_turn) * longint'(gain);
        pm  = ((p < 0) ? -p : p) >> 12;
        acc = longint'(inertia) + ((p < 0) ? -longint'(pm) : longint'(pm));
        if (acc > 2097151) acc = 2097151;
        if (acc < -2097152) acc = -2097152;
        s    = ((w < 0) ? -longint'(rmag) : longint'(rmag)) + acc * 32768;
        smag = (s < 0) ? -s : s;
        lmag = (lin < 0) ? -lin : lin;
        t    = (lmag * smag) >> 30;
        t    = (t * sens) >> 12;
        if (s < 0) ang = (t > 131072) ? -131072 : -longint'(t);
        else ang = (t > 131071) ? 131071 : longint'(t);
        if (acc > 32768) acc -= 32768;
        else if (acc < -32768) acc += 32768;
        else acc = 0;
        inertia = int'(acc);
      end
      last_turn = w;
      last_thr  = v;
      c.linear     = lin[15:0];
      c.angular    = ang[17:0];
      c.point_turn = point_turn;
      pending_cmds.push_back(c);
    endfunction

    // Returns an empty string when the command matches the oldest prediction.
    function string check_result(logic signed [15:0] lin, logic signed [17:0] ang,
                                 logic point_turn);
      drive_cmd_t c;
      string      msg;
      if (pending_cmds.size() == 0)
        return $sformatf("command lin=%0d ang=%0d with no pending prediction", lin, ang);
      c = pending_cmds.pop_front();
      n_checked++;
      msg = "";
      if (lin !== c.linear)
        msg = {msg, $sformatf(" linear got %0d want %0d", lin, c.linear)};
      if (ang !== c.angular)
        msg = {msg, $sformatf(" angular got %0d want %0d", ang, c.angular)};
      if (point_turn !== c.point_turn)
        msg = {msg, $sformatf(" point_turn got %0b want %0b", point_turn, c.point_turn)};
      if (msg != "") msg = {$sformatf("command %0d:", n_checked), msg};
      return msg;
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [cdm_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [cdm_pkg::CFG_DATA_W-1:0] cfg_data_i;

  cdm_in_if  in_ch ();
  cdm_out_if out_ch ();

  curvature_drive_mixer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  drive_scoreboard sb = new();
  int  n_errors;
  int  n_samples;
  int  burst_left;
  bit  hold_request;
  bit  hold_done;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  task automatic report_mismatch(string msg);
    n_errors++;
    $display("MISMATCH @%0t %s", $realtime, msg);
  endtask

  task automatic write_reg(cdm_pkg::cfg_idx_e idx, int unsigned val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[15:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic load_setting(int unsigned db, int unsigned sl, int unsigned nl,
                              int unsigned gn, int unsigned sn);
    write_reg(cdm_pkg::CFG_DEADBAND, db);
    write_reg(cdm_pkg::CFG_SLEW, sl);
    write_reg(cdm_pkg::CFG_NONLINEAR, nl);
    write_reg(cdm_pkg::CFG_INERTIA, gn);
    write_reg(cdm_pkg::CFG_SENSITIVITY, sn);
    @(posedge clk_i);
  endtask

  // Hold valid until the sample is taken; the transaction is noted at that edge.
  task automatic send_sample(logic [15:0] v, logic [15:0] w);
    in_ch.valid       <= 1'b1;
    in_ch.throttle_in <= v;
    in_ch.turn_in     <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_sample(int'($signed(v)), int'($signed(w)));
    n_samples++;
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Settle after a phase: every command back, then the block's latency.
  task automatic drain();
    drop_valid();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_value(int unsigned db);
    int d;
    case ($urandom_range(0, 6))
      0:       return 16'($urandom);
      1:       return 16'($urandom);
      2: begin
        d = $urandom_range(0, 6) - 3;
        return 16'(int'(db) + d);
      end
      3: begin
        d = $urandom_range(0, 6) - 3;
        return 16'(-int'(db) + d);
      end
      4:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      5:       return 16'($urandom_range(0, 2 * db + 1) - int'(db));
      default: return 16'($urandom_range(0, 255) - 128);
    endcase
  endfunction

  task automatic run_random(int n);
    int gap;
    logic [15:0] v, w;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      v = pick_value(sb.deadband);
      w = pick_value(sb.deadband);
      // Point-turn bias: throttle forced near zero, turn left as picked.
      if ($urandom_range(0, 4) == 0) v = 16'($urandom_range(0, 64) - 32);
      send_sample(v, w);
    end
  endtask

  // Command side stall pattern; a long hold-off when asked.
  initial begin
    int seg_len;
    int kind;
    out_ch.ready <= 1'b0;
    hold_done = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_request && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_done = 1;
      end
      seg_len = $urandom_range(1, 200);
      kind    = $urandom_range(0, 2);
      repeat (seg_len) begin
        case (kind)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 2) == 0);
          default: out_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      msg = sb.check_result(out_ch.linear_out, out_ch.angular_out, out_ch.turn_in_place);
      if (msg != "") report_mismatch(msg);
    end
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [15:0] dir_v [$];
    logic [15:0] dir_w [$];
    n_errors     = 0;
    n_samples    = 0;
    burst_left   = 0;
    hold_request = 0;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= cdm_pkg::CFG_DEADBAND;
    cfg_data_i        <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.throttle_in <= '0;
    in_ch.turn_in     <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, deadband edges, point turn, slew both ways.
    dir_v = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000,
              16'd1000, 16'd0, 16'd0, 16'd1637, 16'd1638, 16'h7FFF, 16'h8000,
              16'd100, 16'h8000, 16'h0000, 16'hFFFF, 16'h7FFF, 16'hF99A};
    dir_w = '{16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
              16'd20000, 16'd1638, 16'd1639, 16'hEC78, 16'd5000, 16'h8000, 16'h7FFF,
              16'hFF9C, 16'h8000, 16'hFFFF, 16'h0001, 16'h7FFF, 16'hF99A};
    foreach (dir_v[i]) send_sample(dir_v[i], dir_w[i]);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0:       load_setting(0, 0, 1, 0, 0);
        1:       load_setting(32767, 32767, 32768, 65535, 65535);
        2:       load_setting(1638, 3277, 0, 16384, 4096);
        3:       load_setting(500, 20000, 65535, 65535, 8192);
        4:       load_setting(1638, 3277, 16384, 16384, 4096);
        default: load_setting($urandom_range(0, 4000), $urandom_range(0, 32767),
                              $urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 65535));
      endcase
      // Stall the command side long enough that the input backs up.
      if (ph == 4) hold_request = 1;
      run_random(160);
      drain();
    end

    $display("Covered %0d samples, %0d commands checked, %0d point turns, 10 settings.",
             n_samples, sb.n_checked, sb.n_point_turns);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
